// ===== rtl/page_framebuffer_blit_and_window_macros.svh =====
// assertion macros shared by the framebuffer blitter rtl
`ifndef PAGE_FRAMEBUFFER_BLIT_AND_WINDOW_MACROS_SVH
`define PAGE_FRAMEBUFFER_BLIT_AND_WINDOW_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PFB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfb check failed");

// consequent checked in the cycle after the antecedent
`define PFB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfb check failed");

`endif

// ===== rtl/pfb_pkg.sv =====
// shared types and codes of the page framebuffer blitter
`default_nettype none
package pfb_pkg;

	// op codes of an input transfer
	localparam logic [1:0] OP_BLIT_SET = 2'd0;
	localparam logic [1:0] OP_BLIT_OR  = 2'd1;
	localparam logic [1:0] OP_READ     = 2'd2;

	// sequencer states
	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_MERGE = 5'b00100,
		ST_LOW   = 5'b01000,
		ST_HIGH  = 5'b10000
	} state_t;

	// decoded window read
	typedef struct packed {
		logic [7:0] mask;
		logic [2:0] sh;
		logic       err;
	} win_t;

endpackage
`default_nettype wire

// ===== rtl/pfb_ifs.sv =====
// request and response channel interfaces
`default_nettype none
interface pfb_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] origin_x;
	logic [5:0] origin_y;
	logic [8:0] sprite_width;
	logic [3:0] sprite_pages;
	logic [7:0] data_byte;
	logic [6:0] screen_col;
	logic [2:0] screen_page;
	logic [8:0] col_lo;
	logic [8:0] col_hi;
	logic [6:0] row_lo;
	logic [6:0] row_hi;

	modport source (
		output valid, op, origin_x, origin_y, sprite_width, sprite_pages, data_byte,
		output screen_col, screen_page, col_lo, col_hi, row_lo, row_hi,
		input  ready
	);
	modport sink (
		input  valid, op, origin_x, origin_y, sprite_width, sprite_pages, data_byte,
		input  screen_col, screen_page, col_lo, col_hi, row_lo, row_hi,
		output ready
	);
endinterface

interface pfb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] screen_byte;
	logic       window_error;

	modport source (output valid, screen_byte, window_error, input ready);
	modport sink (input valid, screen_byte, window_error, output ready);
endinterface
`default_nettype wire

// ===== rtl/page_framebuffer_blit_and_window.sv =====
// top level of the page framebuffer blitter and window reader
// blit replace: written in the accept cycle, ready stays high for the next transfer
// blit or: read at accept, written back from the merge state through the single ram port pair
// window read: low then high page read, result registered once the output is free, then ready
// reset: ram clearing pass over MAP_COLS*MAP_PAGES entries (2048 by default), req.ready low
// cursor and control registers clear asynchronously on arst_n
`default_nettype none
`include "page_framebuffer_blit_and_window_macros.svh"
module page_framebuffer_blit_and_window #(
	parameter int MAP_COLS     = 256,
	parameter int MAP_PAGES    = 8,
	parameter int SCREEN_COLS  = 128,
	parameter int SCREEN_PAGES = 8
) (
	input wire logic  clk,
	input wire logic  arst_n,
	pfb_req_if.sink   req,
	pfb_rsp_if.source rsp
);
	localparam int            DEPTH = MAP_COLS * MAP_PAGES;
	localparam int            AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);

	pfb_pkg::state_t st_q;
	logic [AW-1:0]   clr_q;

	// transfer decode
	logic accept;
	logic is_set;
	logic is_or;
	logic is_rd;

	// blit target from the cursor
	logic [AW-1:0] blit_addr;
	logic          blit_hit;

	// window decode
	pfb_pkg::win_t win;
	logic [AW-1:0] win_addr_lo;
	logic [AW-1:0] win_addr_hi;

	// ram ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	// per item holding registers
	logic [7:0]    data_q;
	logic [AW-1:0] addr_q;
	pfb_pkg::win_t win_q;
	logic [7:0]    lo_q;

	// output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_err_q;
	logic       load_out;
	logic [15:0] pair;
	logic [7:0]  gathered;

	assign req.ready = (st_q == pfb_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign is_set    = (req.op == pfb_pkg::OP_BLIT_SET);
	assign is_or     = (req.op == pfb_pkg::OP_BLIT_OR);
	assign is_rd     = (req.op == pfb_pkg::OP_READ);

	pfb_cursor #(
		.MAP_COLS  (MAP_COLS),
		.MAP_PAGES (MAP_PAGES),
		.AW        (AW)
	) u_cursor (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (accept && (is_set || is_or)),
		.origin_x     (req.origin_x),
		.origin_y     (req.origin_y),
		.sprite_width (req.sprite_width),
		.sprite_pages (req.sprite_pages),
		.addr         (blit_addr),
		.hit          (blit_hit)
	);

	pfb_window #(
		.MAP_COLS     (MAP_COLS),
		.MAP_PAGES    (MAP_PAGES),
		.SCREEN_COLS  (SCREEN_COLS),
		.SCREEN_PAGES (SCREEN_PAGES),
		.AW           (AW)
	) u_window (
		.screen_col  (req.screen_col),
		.screen_page (req.screen_page),
		.col_lo      (req.col_lo),
		.col_hi      (req.col_hi),
		.row_lo      (req.row_lo),
		.row_hi      (req.row_hi),
		.win         (win),
		.addr_lo     (win_addr_lo),
		.addr_hi     (win_addr_hi)
	);

	pfb_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// write side: clearing pass, or write back, or direct replace
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = blit_addr;
		ram_wdata = req.data_byte;
		priority if (st_q == pfb_pkg::ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (st_q == pfb_pkg::ST_MERGE) begin
			ram_we    = 1'b1;
			ram_waddr = addr_q;
			ram_wdata = ram_rdata | data_q;
		end else if (accept && is_set && blit_hit) begin
			ram_we = 1'b1;
		end else begin
			ram_we = 1'b0;
		end
	end

	// read side: upper window page, or or-target, or lower window page
	// the state machine never reads and writes one entry in the same cycle,
	// and every write lands before the next accepted item reads
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = blit_addr;
		priority if (st_q == pfb_pkg::ST_LOW) begin
			ram_re    = 1'b1;
			ram_raddr = addr_q;
		end else if (accept && is_or && blit_hit) begin
			ram_re = 1'b1;
		end else if (accept && is_rd) begin
			ram_re    = 1'b1;
			ram_raddr = win_addr_lo;
		end else begin
			ram_re = 1'b0;
		end
	end

	// gather eight window bits across the two page bytes
	assign pair     = {ram_rdata, lo_q} >> win_q.sh;
	assign gathered = pair[7:0] & win_q.mask;
	assign load_out = (st_q == pfb_pkg::ST_HIGH) && (!out_valid_q || rsp.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= pfb_pkg::ST_CLEAR;
			clr_q <= '0;
		end else begin
			unique case (st_q)
				pfb_pkg::ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST) begin
						st_q <= pfb_pkg::ST_IDLE;
					end
				end
				pfb_pkg::ST_IDLE: begin
					if (accept && is_or && blit_hit) begin
						st_q <= pfb_pkg::ST_MERGE;
					end else if (accept && is_rd) begin
						st_q <= pfb_pkg::ST_LOW;
					end
				end
				pfb_pkg::ST_MERGE: begin
					st_q <= pfb_pkg::ST_IDLE;
				end
				pfb_pkg::ST_LOW: begin
					st_q <= pfb_pkg::ST_HIGH;
				end
				pfb_pkg::ST_HIGH: begin
					// hold here while the output register is still full
					if (load_out) begin
						st_q <= pfb_pkg::ST_IDLE;
					end
				end
				default: begin
					st_q <= pfb_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= req.data_byte;
			addr_q <= is_rd ? win_addr_hi : blit_addr;
			win_q  <= win;
		end
		if (st_q == pfb_pkg::ST_LOW) begin
			lo_q <= ram_rdata;
		end
		if (load_out) begin
			out_byte_q <= gathered;
			out_err_q  <= win_q.err;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.screen_byte  = out_byte_q;
	assign rsp.window_error = out_err_q;

	`PFB_ASSERT_NEXT(a_read_to_low, accept && is_rd, st_q == pfb_pkg::ST_LOW)
	`PFB_ASSERT_NEXT(a_low_to_high, st_q == pfb_pkg::ST_LOW, st_q == pfb_pkg::ST_HIGH)
	`PFB_ASSERT_NOW(a_no_same_entry, ram_we && ram_re, ram_waddr != ram_raddr)
	`PFB_ASSERT_NOW(a_clear_quiet, st_q == pfb_pkg::ST_CLEAR, !out_valid_q && !ram_re)
endmodule
`default_nettype wire

// ===== rtl/pfb_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module pfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/pfb_cursor.sv =====
// sprite cursor and blit address generation
`default_nettype none
module pfb_cursor #(
	parameter int MAP_COLS  = 256,
	parameter int MAP_PAGES = 8,
	parameter int AW        = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    origin_x,
	input  wire logic [5:0]    origin_y,
	input  wire logic [8:0]    sprite_width,
	input  wire logic [3:0]    sprite_pages,
	output      logic [AW-1:0] addr,
	output      logic          hit
);
	localparam logic [AW-1:0] COLS_A = AW'(MAP_COLS);

	logic [7:0] col_q;
	logic [2:0] page_q;
	logic [7:0] col_inc;
	logic [2:0] page_inc;
	logic [8:0] col;
	logic [3:0] pg;

	assign col_inc  = col_q + 8'd1;
	assign page_inc = page_q + 3'd1;

	// target byte of the current sprite byte
	assign col  = {1'b0, origin_x} + {1'b0, col_q};
	assign pg   = {1'b0, origin_y[5:3]} + {1'b0, page_q};
	assign hit  = (32'(col) < MAP_COLS) && (32'(pg) < MAP_PAGES);
	assign addr = AW'(pg) * COLS_A + AW'(col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			page_q <= '0;
		end else if (step) begin
			if ({1'b0, col_inc} >= sprite_width) begin
				col_q  <= '0;
				page_q <= ({1'b0, page_inc} >= sprite_pages) ? 3'd0 : page_inc;
			end else begin
				col_q <= col_inc;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/pfb_window.sv =====
// window read decode: bit mask, page addresses and bound check
`default_nettype none
module pfb_window #(
	parameter int MAP_COLS     = 256,
	parameter int MAP_PAGES    = 8,
	parameter int SCREEN_COLS  = 128,
	parameter int SCREEN_PAGES = 8,
	parameter int AW           = 11
) (
	input  wire logic [6:0]    screen_col,
	input  wire logic [2:0]    screen_page,
	input  wire logic [8:0]    col_lo,
	input  wire logic [8:0]    col_hi,
	input  wire logic [6:0]    row_lo,
	input  wire logic [6:0]    row_hi,
	output      pfb_pkg::win_t win,
	output      logic [AW-1:0] addr_lo,
	output      logic [AW-1:0] addr_hi
);
	localparam int            ROWS   = 8 * MAP_PAGES;
	localparam logic [AW-1:0] COLS_A = AW'(MAP_COLS);

	logic       in_rng;
	logic       on_scr;
	logic [9:0] x;
	logic       x_ok;
	logic       x_map;
	logic [7:0] ybase;
	logic [4:0] pg_lo;
	logic [5:0] pg_hi;
	logic [8:0] yb;

	assign in_rng = (32'(col_lo) <= MAP_COLS) && (32'(col_hi) <= MAP_COLS)
		&& (32'(row_lo) <= ROWS) && (32'(row_hi) <= ROWS);
	assign on_scr = (32'(screen_col) < SCREEN_COLS) && (32'(screen_page) < SCREEN_PAGES);
	assign x      = {1'b0, col_lo} + {3'b0, screen_col};
	assign x_ok   = x < {1'b0, col_hi};
	assign x_map  = 32'(x) < MAP_COLS;
	assign ybase  = {1'b0, row_lo} + {2'b0, screen_page, 3'b000};
	assign pg_lo  = ybase[7:3];
	assign pg_hi  = {1'b0, pg_lo} + 6'd1;

	always_comb begin
		win.err = !in_rng;
		win.sh  = ybase[2:0];
		for (int b = 0; b < 8; b++) begin
			yb          = {1'b0, ybase} + 9'(b);
			win.mask[b] = in_rng && on_scr && x_ok && (yb < {2'b0, row_hi});
		end
	end

	// a page beyond the map only feeds masked bits, so it reads entry zero
	assign addr_lo = (x_map && (32'(pg_lo) < MAP_PAGES)) ? AW'(pg_lo) * COLS_A + AW'(x) : '0;
	assign addr_hi = (x_map && (32'(pg_hi) < MAP_PAGES)) ? AW'(pg_hi) * COLS_A + AW'(x) : '0;
endmodule
`default_nettype wire

// ===== bench/page_framebuffer_blit_and_window_test.sv =====
// self-checking bench for the page framebuffer blitter and window reader
`default_nettype none
module page_framebuffer_blit_and_window_test;
	timeunit 1ns;
	timeprecision 1ps;

	// op code 3 has no meaning, the block drops it
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int MAP_COLS      = 256;
	localparam int MAP_PAGES     = 8;
	localparam int SCREEN_COLS   = 128;
	localparam int SCREEN_PAGES  = 8;
	localparam int ITEM_TARGET   = 1950;
	// covers the ram clearing pass after reset with plenty of margin
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int DRAIN_CYCLES  = 16;
	localparam int IDLE_PERCENT  = 12;
	localparam int QUIET_FIRST   = 3000;
	localparam int QUIET_LAST    = 4500;

	typedef struct {
		logic [1:0] op;
		logic [7:0] origin_x;
		logic [5:0] origin_y;
		logic [8:0] sprite_width;
		logic [3:0] sprite_pages;
		logic [7:0] data_byte;
		logic [6:0] screen_col;
		logic [2:0] screen_page;
		logic [8:0] col_lo;
		logic [8:0] col_hi;
		logic [6:0] row_lo;
		logic [6:0] row_hi;
		bit         hold;
	} fb_req_t;

	typedef struct {
		logic [7:0] screen_byte;
		logic       window_error;
	} fb_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pfb_req_if req_ch ();
	pfb_rsp_if rsp_ch ();

	page_framebuffer_blit_and_window #(
		.MAP_COLS     (MAP_COLS),
		.MAP_PAGES    (MAP_PAGES),
		.SCREEN_COLS  (SCREEN_COLS),
		.SCREEN_PAGES (SCREEN_PAGES)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	// predicted framebuffer contents and the sprite cursor
	logic [7:0] fb_image [MAP_COLS*MAP_PAGES];
	logic [7:0] blit_col;
	logic [2:0] blit_page;

	fb_req_t pending_reqs [$];
	fb_rsp_t expected_reads [$];

	int  err_count = 0;
	int  item_count = 0;
	int  cyc = 0;
	int  stall_cycles = 0;
	bit  hold_next = 1'b0;
	logic quiet_stretch;

	// one long window where neither side idles at random
	assign quiet_stretch = (cyc >= QUIET_FIRST) && (cyc < QUIET_LAST);

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0h expected %0h", cyc, what, got, want);
		err_count++;
	endtask

	function automatic bit map_bit(input logic [9:0] x, input logic [7:0] y);
		if (x >= MAP_COLS || (y >> 3) >= MAP_PAGES)
			return 1'b0;
		return fb_image[(y >> 3) * MAP_COLS + x][y[2:0]];
	endfunction

	// updates the image and cursor, returns 1 when a result is due
	function automatic bit predict_transfer(input fb_req_t t, output fb_rsp_t r);
		logic [8:0] col;
		logic [3:0] page;
		logic [8:0] next_col;
		logic [3:0] next_page;
		logic [9:0] x;
		logic [7:0] y;
		int idx;
		r.screen_byte = 8'd0;
		r.window_error = 1'b0;
		if (t.op == pfb_pkg::OP_BLIT_SET || t.op == pfb_pkg::OP_BLIT_OR) begin
			col = t.origin_x + blit_col;
			page = t.origin_y[5:3] + blit_page;
			// writes past the map edge are dropped, the cursor moves anyway
			if (col < MAP_COLS && page < MAP_PAGES) begin
				idx = page * MAP_COLS + col;
				if (t.op == pfb_pkg::OP_BLIT_SET)
					fb_image[idx] = t.data_byte;
				else
					fb_image[idx] = fb_image[idx] | t.data_byte;
			end
			// a zero width wraps the column on every byte, a zero height wraps the page at each column wrap
			next_col = {1'b0, blit_col + 8'd1};
			if (next_col >= t.sprite_width) begin
				blit_col = 8'd0;
				next_page = {1'b0, blit_page + 3'd1};
				blit_page = (next_page >= t.sprite_pages) ? 3'd0 : next_page[2:0];
			end else begin
				blit_col = next_col[7:0];
			end
			return 1'b0;
		end
		if (t.op == pfb_pkg::OP_READ) begin
			if (t.col_lo > MAP_COLS || t.col_hi > MAP_COLS
				|| t.row_lo > 8*MAP_PAGES || t.row_hi > 8*MAP_PAGES) begin
				r.window_error = 1'b1;
			end else if (t.screen_col < SCREEN_COLS && t.screen_page < SCREEN_PAGES) begin
				x = t.col_lo + t.screen_col;
				// pixels outside the window read as zero
				if (x < t.col_hi) begin
					for (int b = 0; b < 8; b++) begin
						y = 8'(t.row_lo + 8 * t.screen_page + b);
						if (y < t.row_hi && map_bit(x, y))
							r.screen_byte[b] = 1'b1;
					end
				end
			end
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic push_blit(input logic [1:0] op, input logic [7:0] ox, input logic [5:0] oy,
		input logic [8:0] w, input logic [3:0] pg, input logic [7:0] d);
		fb_req_t t;
		t = '{default: '0};
		t.op = op;
		t.origin_x = ox;
		t.origin_y = oy;
		t.sprite_width = w;
		t.sprite_pages = pg;
		t.data_byte = d;
		t.hold = hold_next;
		hold_next = 1'b0;
		pending_reqs.push_back(t);
		item_count++;
	endtask

	task automatic push_read(input logic [6:0] sc, input logic [2:0] sp,
		input logic [8:0] c0, input logic [8:0] c1, input logic [6:0] r0, input logic [6:0] r1);
		fb_req_t t;
		t = '{default: '0};
		t.op = pfb_pkg::OP_READ;
		t.screen_col = sc;
		t.screen_page = sp;
		t.col_lo = c0;
		t.col_hi = c1;
		t.row_lo = r0;
		t.row_hi = r1;
		t.hold = hold_next;
		hold_next = 1'b0;
		pending_reqs.push_back(t);
		item_count++;
	endtask

	// request driver: holds a transfer until ready, idles at random,
	// and parks a marked item until every read answer is in
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (pending_reqs.size() == 0) begin
				req_ch.valid <= 1'b0;
			end else if (!quiet_stretch && $urandom_range(0, 99) < IDLE_PERCENT) begin
				req_ch.valid <= 1'b0;
			end else if (pending_reqs[0].hold && (expected_reads.size() != 0 || req_ch.valid
				|| (rsp_ch.valid && rsp_ch.ready))) begin
				// a transfer or answer at this edge may still change the count
				req_ch.valid <= 1'b0;
			end else begin
				req_ch.valid        <= 1'b1;
				req_ch.op           <= pending_reqs[0].op;
				req_ch.origin_x     <= pending_reqs[0].origin_x;
				req_ch.origin_y     <= pending_reqs[0].origin_y;
				req_ch.sprite_width <= pending_reqs[0].sprite_width;
				req_ch.sprite_pages <= pending_reqs[0].sprite_pages;
				req_ch.data_byte    <= pending_reqs[0].data_byte;
				req_ch.screen_col   <= pending_reqs[0].screen_col;
				req_ch.screen_page  <= pending_reqs[0].screen_page;
				req_ch.col_lo       <= pending_reqs[0].col_lo;
				req_ch.col_hi       <= pending_reqs[0].col_hi;
				req_ch.row_lo       <= pending_reqs[0].row_lo;
				req_ch.row_hi       <= pending_reqs[0].row_hi;
				void'(pending_reqs.pop_front());
			end
		end
	end

	// response back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	// monitor: predict on each request transfer, check each response transfer
	always @(posedge clk) begin
		fb_req_t seen;
		fb_rsp_t want;
		bit req_xfer;
		bit rsp_xfer;
		req_xfer = arst_n && req_ch.valid === 1'b1 && req_ch.ready === 1'b1;
		rsp_xfer = arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1;
		cyc <= cyc + 1;
		stall_cycles <= (req_xfer || rsp_xfer) ? 0 : stall_cycles + 1;
		if (req_xfer) begin
			seen = '{default: '0};
			seen.op           = req_ch.op;
			seen.origin_x     = req_ch.origin_x;
			seen.origin_y     = req_ch.origin_y;
			seen.sprite_width = req_ch.sprite_width;
			seen.sprite_pages = req_ch.sprite_pages;
			seen.data_byte    = req_ch.data_byte;
			seen.screen_col   = req_ch.screen_col;
			seen.screen_page  = req_ch.screen_page;
			seen.col_lo       = req_ch.col_lo;
			seen.col_hi       = req_ch.col_hi;
			seen.row_lo       = req_ch.row_lo;
			seen.row_hi       = req_ch.row_hi;
			if (predict_transfer(seen, want))
				expected_reads.push_back(want);
		end
		if (rsp_xfer) begin
			if (expected_reads.size() == 0) begin
				report_mismatch("unexpected response, screen_byte",
					int'(rsp_ch.screen_byte), 0);
			end else begin
				want = expected_reads.pop_front();
				if (rsp_ch.screen_byte !== want.screen_byte)
					report_mismatch("screen_byte", int'(rsp_ch.screen_byte),
						int'(want.screen_byte));
				if (rsp_ch.window_error !== want.window_error)
					report_mismatch("window_error", int'(rsp_ch.window_error),
						int'(want.window_error));
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	initial begin
		wait (stall_cycles >= WATCHDOG_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		fb_req_t t;
		logic [1:0] op;
		logic [7:0] ox;
		logic [5:0] oy;
		logic [8:0] w;
		logic [3:0] pg;
		logic [8:0] c0;
		logic [8:0] c1;
		logic [6:0] r0;
		logic [6:0] r1;
		int pick;

		// every input known from time zero
		req_ch.valid = 1'b0;
		req_ch.op = pfb_pkg::OP_BLIT_SET;
		req_ch.origin_x = '0;
		req_ch.origin_y = '0;
		req_ch.sprite_width = '0;
		req_ch.sprite_pages = '0;
		req_ch.data_byte = '0;
		req_ch.screen_col = '0;
		req_ch.screen_page = '0;
		req_ch.col_lo = '0;
		req_ch.col_hi = '0;
		req_ch.row_lo = '0;
		req_ch.row_hi = '0;
		rsp_ch.ready = 1'b0;
		foreach (fb_image[i])
			fb_image[i] = 8'd0;
		blit_col = 8'd0;
		blit_page = 3'd0;

		// directed part
		// whole map window straight after the clearing pass
		push_read(7'd0, 3'd0, 9'd0, 9'd256, 7'd0, 7'd64);
		// 2x2 sprite in the bottom right corner, two bytes fall off the map
		push_blit(pfb_pkg::OP_BLIT_SET, 8'd254, 6'd56, 9'd2, 4'd2, 8'hff);
		push_blit(pfb_pkg::OP_BLIT_SET, 8'd254, 6'd56, 9'd2, 4'd2, 8'h3c);
		push_blit(pfb_pkg::OP_BLIT_SET, 8'd254, 6'd56, 9'd2, 4'd2, 8'h81);
		push_blit(pfb_pkg::OP_BLIT_SET, 8'd254, 6'd56, 9'd2, 4'd2, 8'h42);
		// or merge over the corner byte
		push_blit(pfb_pkg::OP_BLIT_OR, 8'd254, 6'd63, 9'd1, 4'd1, 8'h00);
		push_blit(pfb_pkg::OP_BLIT_OR, 8'd255, 6'd56, 9'd1, 4'd1, 8'h0f);
		// zero width and zero height wrap on every byte
		push_blit(pfb_pkg::OP_BLIT_SET, 8'd0, 6'd0, 9'd0, 4'd0, 8'ha5);
		push_blit(pfb_pkg::OP_BLIT_OR, 8'd0, 6'd0, 9'd0, 4'd0, 8'h5a);
		// oversized sprite, then a zero size byte brings the cursor home
		push_blit(pfb_pkg::OP_BLIT_SET, 8'd10, 6'd8, 9'd511, 4'd15, 8'h81);
		push_blit(pfb_pkg::OP_BLIT_SET, 8'd10, 6'd8, 9'd511, 4'd15, 8'h7e);
		push_blit(pfb_pkg::OP_BLIT_SET, 8'd255, 6'd7, 9'd0, 4'd0, 8'hc3);
		// window bounds beyond the map
		push_read(7'd0, 3'd0, 9'd257, 9'd300, 7'd65, 7'd127);
		push_read(7'd127, 3'd7, 9'd511, 9'd511, 7'd127, 7'd127);
		push_read(7'd5, 3'd0, 9'd0, 9'd256, 7'd0, 7'd65);
		// empty windows
		push_read(7'd0, 3'd0, 9'd10, 9'd10, 7'd0, 7'd64);
		push_read(7'd0, 3'd0, 9'd0, 9'd256, 7'd20, 7'd5);
		// rows straddle pages six and seven at column 254
		push_read(7'd127, 3'd6, 9'd127, 9'd256, 7'd3, 7'd64);
		// column past the window bound
		push_read(7'd5, 3'd0, 9'd0, 9'd1, 7'd0, 7'd64);
		// window starting at the map edge
		push_read(7'd0, 3'd0, 9'd256, 9'd256, 7'd0, 7'd64);
		// bottom rows clipped by the window
		push_read(7'd127, 3'd7, 9'd128, 9'd256, 7'd0, 7'd60);
		push_read(7'd10, 3'd1, 9'd0, 9'd256, 7'd0, 7'd64);
		push_read(7'd0, 3'd0, 9'd0, 9'd256, 7'd0, 7'd64);
		// ignored op
		t = '{default: '0};
		t.op = OP_UNUSED;
		t.col_hi = 9'd256;
		t.row_hi = 7'd64;
		pending_reqs.push_back(t);

		// random part, first item waits for an empty response pipe
		hold_next = 1'b1;
		while (item_count < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				// whole sprite, cursor starts at its origin
				op = $urandom_range(0, 1) ? pfb_pkg::OP_BLIT_OR : pfb_pkg::OP_BLIT_SET;
				ox = 8'($urandom_range(0, 255));
				oy = 6'($urandom_range(0, 63));
				if ($urandom_range(0, 29) == 0) begin
					w = 9'($urandom_range(64, 256));
					pg = 4'd1;
				end else begin
					w = 9'($urandom_range(1, 16));
					pg = 4'($urandom_range(1, 3));
				end
				if ($urandom_range(0, 19) == 0)
					hold_next = 1'b1;
				for (int k = 0; k < int'(w) * int'(pg); k++)
					push_blit(op, ox, oy, w, pg, 8'($urandom));
			end else if (pick < 85) begin
				// windows mostly inside the map so the gathered bits carry data
				repeat ($urandom_range(1, 4)) begin
					c0 = 9'($urandom_range(0, 128));
					c1 = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(c0, 256)) : 9'd256;
					r0 = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 64))
						: 7'($urandom_range(0, 7));
					r1 = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(r0, 64)) : 7'd64;
					push_read(7'($urandom), 3'($urandom), c0, c1, r0, r1);
				end
			end else begin
				// raw noise across every field, including the unused op
				t.op = 2'($urandom_range(0, 3));
				t.origin_x = 8'($urandom);
				t.origin_y = 6'($urandom);
				t.sprite_width = 9'($urandom);
				t.sprite_pages = 4'($urandom);
				t.data_byte = 8'($urandom);
				t.screen_col = 7'($urandom);
				t.screen_page = 3'($urandom);
				t.col_lo = 9'($urandom);
				t.col_hi = 9'($urandom);
				t.row_lo = 7'($urandom);
				t.row_hi = 7'($urandom);
				t.hold = 1'b0;
				pending_reqs.push_back(t);
				if (t.op != OP_UNUSED)
					item_count++;
				// a zero size byte puts the cursor back at the sprite origin
				if (t.op == pfb_pkg::OP_BLIT_SET || t.op == pfb_pkg::OP_BLIT_OR)
					push_blit(pfb_pkg::OP_BLIT_OR, 8'($urandom), 6'($urandom), 9'd0, 4'd0,
						8'($urandom));
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || req_ch.valid || expected_reads.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/pfb_pkg.sv
rtl/pfb_ifs.sv
rtl/pfb_ram.sv
rtl/pfb_cursor.sv
rtl/pfb_window.sv
rtl/page_framebuffer_blit_and_window.sv
bench/page_framebuffer_blit_and_window_test.sv
